>>> hdl/tdc_fine_time_code_density_calibration_assert.svh
// Assertion macros shared by the fine-time calibration RTL.
`ifndef TDC_FINE_TIME_CODE_DENSITY_CALIBRATION_ASSERT_SVH
`define TDC_FINE_TIME_CODE_DENSITY_CALIBRATION_ASSERT_SVH
`ifndef SYNTH
`define TDC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TDC_ASSERT_SAME(lbl, ante, cons)
`define TDC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/tdc_cal_pkg.sv
// Shared constants of the fine-time code density calibration block.
package tdc_cal_pkg;
    localparam int NUM_MODULES_DEF         = 4;
    localparam int CHANNELS_PER_MODULE_DEF = 16;
    localparam int NBINS_DEF               = 256;
    localparam int COUNT_WIDTH_DEF         = 20;

    localparam int TOTAL_W  = 28;
    localparam int FRAC_W   = 16;
    localparam int CORR_W   = 16;
    localparam int QUO_W    = 17;
    localparam int FMIN_W   = 10;
    localparam int FMAX_W   = 11;
    localparam int FT_W     = 10;
    localparam int QBIN_W   = 8;
    localparam int MOD_W    = 2;
    localparam int CH_W     = 4;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 88;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FINE_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINE_MAX = 1'd1;
    localparam logic [FMAX_W-1:0]    FINE_MAX_RESET = 11'd1024;

    localparam logic CMD_HIT   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
endpackage

>>> hdl/tdc_fine_time_code_density_calibration.sv
// Fine-time code density calibration: histogram memory, walk and divider sequencer.
//
//  Channel     Dir  Beat contents
//  s_axis      in   tdata: module_req, channel, fine_time, bin; tuser: cmd
//  m_axis      out  tdata: module_out, channel_out, bin_out, correction, cumulative,
//                   total, fired
//  cfg         in   i_cfg_we, i_cfg_addr (0 fine_min, 1 fine_max), i_cfg_wdata
//
// An in-range hit passes the one-bit-per-cycle bin divider (S_HDIV), then the
// read-modify-write of the histogram memory (S_HRD, S_HWR). A dropped hit is accepted
// and leaves the sequencer in S_IDLE. A query of a fired channel walks the histogram
// memory one bin per read from bin 0 to the queried bin (S_QWALK, S_QDRAIN), then runs
// the correction division and bookkeeping (S_QMUL, S_QSUB, S_QLD, S_QDIV) before S_OUT; a
// query of a channel that never fired goes straight to S_OUT.
// After reset the histogram memory is swept to zero over all NUM_MODULES *
// CHANNELS_PER_MODULE * NBINS entries while s_axis_tready stays low.
// A waiting result stalls the next query in S_OUT; hits flow until that query blocks.
`include "tdc_fine_time_code_density_calibration_assert.svh"
module tdc_fine_time_code_density_calibration #(
    parameter int NUM_MODULES         = tdc_cal_pkg::NUM_MODULES_DEF,
    parameter int CHANNELS_PER_MODULE = tdc_cal_pkg::CHANNELS_PER_MODULE_DEF,
    parameter int NBINS               = tdc_cal_pkg::NBINS_DEF,
    parameter int COUNT_WIDTH         = tdc_cal_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // module_req[1:0], channel[5:2], fine_time[15:6], bin[23:16]
    input  logic [tdc_cal_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // cmd[0]
    input  logic [0:0]                              s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // module_out[1:0], channel_out[5:2], bin_out[13:6], correction[29:14],
    // cumulative[57:30], total[85:58], fired[86], zero[87]
    output logic [tdc_cal_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                    i_cfg_we,
    input  logic [tdc_cal_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [tdc_cal_pkg::FMAX_W-1:0]          i_cfg_wdata
);
    localparam int TOTAL_W = tdc_cal_pkg::TOTAL_W;
    localparam int FMAX_W  = tdc_cal_pkg::FMAX_W;
    localparam int FMIN_W  = tdc_cal_pkg::FMIN_W;
    localparam int QUO_W   = tdc_cal_pkg::QUO_W;
    localparam int CORR_W  = tdc_cal_pkg::CORR_W;
    localparam int NCHAN   = NUM_MODULES * CHANNELS_PER_MODULE;
    localparam int CIW     = (NCHAN > 1) ? $clog2(NCHAN) : 1;
    localparam int NBW     = $clog2(NBINS);
    localparam int BCW     = $clog2(NBINS + 1);
    localparam int DEPTH   = NCHAN * NBINS;
    localparam int AW      = $clog2(DEPTH);
    localparam int HNW     = tdc_cal_pkg::FT_W + BCW;
    localparam int DENW    = TOTAL_W + BCW;
    localparam int NW      = DENW + tdc_cal_pkg::FRAC_W + 1;
    localparam int RW      = DENW + 2;
    localparam int DCW     = $clog2(NW + 1);
    localparam int SW      = ((TOTAL_W > COUNT_WIDTH) ? TOTAL_W : COUNT_WIDTH) + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [TOTAL_W-1:0]     TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_HDIV   = 4'd2;
    localparam logic [3:0] S_HRD    = 4'd3;
    localparam logic [3:0] S_HWR    = 4'd4;
    localparam logic [3:0] S_QWALK  = 4'd5;
    localparam logic [3:0] S_QDRAIN = 4'd6;
    localparam logic [3:0] S_QMUL   = 4'd7;
    localparam logic [3:0] S_QSUB   = 4'd8;
    localparam logic [3:0] S_QLD    = 4'd9;
    localparam logic [3:0] S_QDIV   = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0]               r_state;
    logic [3:0]               n_state;
    logic [FMIN_W-1:0]        r_fmin;
    logic [FMAX_W-1:0]        r_fmax;
    logic [NCHAN-1:0]         r_fired;
    logic [AW-1:0]            r_clr_addr;

    logic [COUNT_WIDTH-1:0]   bc_mem [DEPTH];
    logic [COUNT_WIDTH-1:0]   r_bc_rd;
    logic [TOTAL_W-1:0]       tot_mem [NCHAN];
    logic [TOTAL_W-1:0]       r_tot_rd;

    logic [CIW-1:0]           r_idx;
    logic [tdc_cal_pkg::MOD_W-1:0]  r_mod;
    logic [tdc_cal_pkg::CH_W-1:0]   r_ch;
    logic [tdc_cal_pkg::QBIN_W-1:0] r_qbin;
    logic [NBW-1:0]           r_b;
    logic [NBW-1:0]           r_k;
    logic                     r_rdv;
    logic [TOTAL_W-1:0]       r_acc;
    logic [TOTAL_W-1:0]       r_total;
    logic                     r_qfired;
    logic [DENW-1:0]          r_a;
    logic [DENW-1:0]          r_c;
    logic [DENW-1:0]          r_den;
    logic [DENW-1:0]          r_mag;
    logic                     r_neg;

    logic [NW-1:0]            r_dnum;
    logic [RW-1:0]            r_rem;
    logic [RW-1:0]            r_dden;
    logic [QUO_W-1:0]         r_quo;
    logic [DCW-1:0]           r_dcnt;

    logic                     r_ov;
    logic [tdc_cal_pkg::OUT_TDATA_W-1:0] r_odata;

    logic [tdc_cal_pkg::MOD_W-1:0]  in_mod;
    logic [tdc_cal_pkg::CH_W-1:0]   in_ch;
    logic [tdc_cal_pkg::FT_W-1:0]   in_ft;
    logic [tdc_cal_pkg::QBIN_W-1:0] in_qbin;
    logic                     in_cmd;
    logic                     in_ok;
    logic [CIW-1:0]           in_idx;
    logic                     in_range;
    logic [HNW-1:0]           hit_num;
    logic [NBW-1:0]           in_qb;
    logic                     in_acc;

    logic [RW-1:0]            div_sh;
    logic                     div_ge;
    logic [RW-1:0]            div_rem;
    logic [AW-1:0]            base;
    logic [AW-1:0]            bc_raddr;
    logic                     bc_we;
    logic [AW-1:0]            bc_waddr;
    logic [COUNT_WIDTH-1:0]   bc_wdata;
    logic [TOTAL_W-1:0]       tot_old;
    logic [TOTAL_W-1:0]       tot_new;
    logic [SW-1:0]            acc_sum;
    logic [TOTAL_W-1:0]       acc_sat;
    logic [CORR_W-1:0]        q16;
    logic [CORR_W-1:0]        corr;
    logic                     out_load;

    assign in_mod  = s_axis_tdata[1:0];
    assign in_ch   = s_axis_tdata[5:2];
    assign in_ft   = s_axis_tdata[15:6];
    assign in_qbin = s_axis_tdata[23:16];
    assign in_cmd  = s_axis_tuser[0];
    assign in_ok   = (32'(in_mod) < NUM_MODULES) && (32'(in_ch) < CHANNELS_PER_MODULE);
    assign in_idx  = in_ok ? CIW'(32'(in_mod) * CHANNELS_PER_MODULE + 32'(in_ch)) : '0;
    assign in_range = (FMAX_W'(r_fmin) < r_fmax) && (in_ft >= r_fmin)
                      && (FMAX_W'(in_ft) < r_fmax);
    assign hit_num = HNW'(32'(in_ft - r_fmin) * NBINS);
    assign in_qb   = (32'(in_qbin) < NBINS) ? NBW'(in_qbin) : NBW'(NBINS - 1);

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign div_sh  = {r_rem[RW-2:0], r_dnum[NW-1]};
    assign div_ge  = (div_sh >= r_dden);
    assign div_rem = div_ge ? (div_sh - r_dden) : div_sh;

    assign base     = AW'(32'(r_idx) * NBINS);
    assign bc_raddr = (r_state == S_QWALK) ? (base + AW'(r_k))
                                           : (base + AW'(r_quo[NBW-1:0]));
    assign bc_we    = (r_state == S_CLEAR) || (r_state == S_HWR);
    assign bc_waddr = (r_state == S_CLEAR) ? r_clr_addr : bc_raddr;
    assign bc_wdata = (r_state == S_CLEAR) ? '0
                    : ((r_bc_rd == COUNT_MAX) ? r_bc_rd : r_bc_rd + 1'b1);

    assign tot_old = r_fired[r_idx] ? r_tot_rd : '0;
    assign tot_new = (tot_old == TOTAL_MAX) ? tot_old : tot_old + 1'b1;

    assign acc_sum = SW'(r_acc) + SW'(r_bc_rd);
    assign acc_sat = (acc_sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(acc_sum);

    assign q16 = CORR_W'(r_quo);
    always_comb begin
        if (!r_qfired || (r_total == '0)) begin
            corr = '0;
        end else if (r_neg) begin
            corr = (r_quo > QUO_W'(32768)) ? 16'h8000 : (~q16 + 1'b1);
        end else begin
            corr = (r_quo > QUO_W'(32767)) ? 16'h7FFF : q16;
        end
    end

    assign out_load = (r_state == S_OUT) && (!r_ov || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_clr_addr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    if (in_cmd == tdc_cal_pkg::CMD_QUERY) begin
                        n_state = (in_ok && r_fired[in_idx]) ? S_QWALK : S_OUT;
                    end else if (in_ok && in_range) begin
                        n_state = S_HDIV;
                    end
                end
            end
            S_HDIV:   if (r_dcnt == DCW'(1)) n_state = S_HRD;
            S_HRD:    n_state = S_HWR;
            S_HWR:    n_state = S_IDLE;
            S_QWALK:  if (r_k == r_b) n_state = S_QDRAIN;
            S_QDRAIN: n_state = S_QMUL;
            S_QMUL:   n_state = S_QSUB;
            S_QSUB:   n_state = S_QLD;
            S_QLD:    n_state = S_QDIV;
            S_QDIV:   if (r_dcnt == DCW'(1)) n_state = S_OUT;
            S_OUT:    if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (bc_we) begin
            bc_mem[bc_waddr] <= bc_wdata;
        end
        r_bc_rd <= bc_mem[bc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_HWR) begin
            tot_mem[r_idx] <= tot_new;
        end
        r_tot_rd <= tot_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_fired    <= '0;
            r_ov       <= 1'b0;
            r_fmin     <= '0;
            r_fmax     <= tdc_cal_pkg::FINE_MAX_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    tdc_cal_pkg::CFG_FINE_MIN: r_fmin <= i_cfg_wdata[FMIN_W-1:0];
                    tdc_cal_pkg::CFG_FINE_MAX: r_fmax <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_state == S_HWR) begin
                r_fired[r_idx] <= 1'b1;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_idx    <= in_idx;
                    r_mod    <= in_mod;
                    r_ch     <= in_ch;
                    r_qbin   <= in_qbin;
                    r_b      <= in_qb;
                    r_k      <= '0;
                    r_rdv    <= 1'b0;
                    r_acc    <= '0;
                    r_total  <= '0;
                    r_qfired <= in_ok && r_fired[in_idx];
                    r_dnum   <= NW'(hit_num) << (NW - HNW);
                    r_rem    <= '0;
                    r_dden   <= RW'(r_fmax - FMAX_W'(r_fmin));
                    r_dcnt   <= DCW'(HNW);
                end
            end
            S_HDIV, S_QDIV: begin
                r_rem  <= div_rem;
                r_dnum <= r_dnum << 1;
                r_quo  <= {r_quo[QUO_W-2:0], div_ge};
                r_dcnt <= r_dcnt - 1'b1;
            end
            S_QWALK: begin
                r_k   <= r_k + 1'b1;
                r_rdv <= 1'b1;
                if (r_rdv) r_acc <= acc_sat;
            end
            S_QDRAIN: begin
                r_acc <= acc_sat;
                r_rdv <= 1'b0;
            end
            S_QMUL: begin
                r_a     <= DENW'(r_acc) * DENW'(NBINS);
                r_c     <= (DENW'(r_b) + 1'b1) * DENW'(r_tot_rd);
                r_den   <= DENW'(r_tot_rd) * DENW'(NBINS);
                r_total <= r_tot_rd;
            end
            S_QSUB: begin
                r_neg <= (r_a < r_c);
                r_mag <= (r_a < r_c) ? (r_c - r_a) : (r_a - r_c);
            end
            S_QLD: begin
                r_dnum <= (NW'(r_mag) << tdc_cal_pkg::FRAC_W) + NW'(r_den);
                r_rem  <= '0;
                r_dden <= RW'(r_den) << 1;
                r_dcnt <= DCW'(NW);
            end
            S_OUT: begin
                if (out_load) begin
                    r_odata <= {1'b0, r_qfired, r_total, r_acc, corr, r_qbin, r_ch, r_mod};
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;

    `TDC_ASSERT_SAME(a_walk_in_range, r_state == S_QWALK, r_k <= r_b)
    `TDC_ASSERT_NEXT(a_hit_marks_fired, r_state == S_HWR, r_fired[$past(r_idx)])
    `TDC_ASSERT_SAME(a_fired_total_nonzero, r_state == S_QMUL, r_tot_rd != '0)
    `TDC_ASSERT_SAME(a_result_from_out, $rose(r_ov), $past(r_state) == S_OUT)
endmodule
